// ===== src/rhc_pkg.sv =====
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int FRACTION_BITS_DEF = 16;

    // Control that rides along with each item through the divider chain
    typedef struct packed {
        logic valid;
        logic sat_full;   // saturation reaches one full unit: output all ones
    } ctl_t;

endpackage

// ===== src/rgb_to_hsv_converter.sv =====
// Registers from start to done: front stage, FRACTION_BITS divider cells, output register.
// Throughput: one item per clock; busy is never raised, as the chain of FRACTION_BITS
// divider cells (one quotient bit each for hue and saturation) takes an item every cycle.
// Results appear on done for one cycle; the receiver cannot stall them.
// Reset (rst_n, asynchronous, active low) clears every valid flag; no item is in flight after it.
`timescale 1ns / 1ps

module rgb_to_hsv_converter
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CHANNEL_BITS-1:0]  red_level,
    input  logic [CHANNEL_BITS-1:0]  green_level,
    input  logic [CHANNEL_BITS-1:0]  blue_level,
    output logic                     done,
    output logic [FRACTION_BITS-1:0] hue_turn,
    output logic [FRACTION_BITS-1:0] saturation_frac,
    output logic [CHANNEL_BITS-1:0]  value_level
);

    localparam int HW = CHANNEL_BITS + 3;

    // Stage k of the chain holds the item after k quotient bits have been produced.
    ctl_t                     ctl_w   [0:FRACTION_BITS];
    logic [CHANNEL_BITS-1:0]  value_w [0:FRACTION_BITS];
    logic [CHANNEL_BITS-1:0]  rem_s_w [0:FRACTION_BITS];
    logic [CHANNEL_BITS-1:0]  div_s_w [0:FRACTION_BITS];
    logic [FRACTION_BITS-1:0] q_s_w   [0:FRACTION_BITS];
    logic [HW-1:0]            rem_h_w [0:FRACTION_BITS];
    logic [HW-1:0]            div_h_w [0:FRACTION_BITS];
    logic [FRACTION_BITS-1:0] q_h_w   [0:FRACTION_BITS];

    logic                     done_reg, done_next;
    logic [FRACTION_BITS-1:0] hue_reg,  hue_next;
    logic [FRACTION_BITS-1:0] sat_reg,  sat_next;
    logic [CHANNEL_BITS-1:0]  val_reg;

    // Never stalls: a new pixel may enter on every clock.
    assign busy = 1'b0;

    // Front stage: max, min, sector numerator and both divisors.
    rhc_prep #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (start && !busy),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .ctl         (ctl_w[0]),
        .value       (value_w[0]),
        .rem_s       (rem_s_w[0]),
        .div_s       (div_s_w[0]),
        .rem_h       (rem_h_w[0]),
        .div_h       (div_h_w[0])
    );

    assign q_s_w[0] = '0;
    assign q_h_w[0] = '0;

    // Row of identical cells, each shifting one bit into both quotients.
    for (genvar k = 0; k < FRACTION_BITS; k++)
    begin : g_cell
        rhc_div_cell #(
            .CHANNEL_BITS  (CHANNEL_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl_w[k]),
            .value_in  (value_w[k]),
            .rem_s_in  (rem_s_w[k]),
            .div_s_in  (div_s_w[k]),
            .q_s_in    (q_s_w[k]),
            .rem_h_in  (rem_h_w[k]),
            .div_h_in  (div_h_w[k]),
            .q_h_in    (q_h_w[k]),
            .ctl_out   (ctl_w[k+1]),
            .value_out (value_w[k+1]),
            .rem_s_out (rem_s_w[k+1]),
            .div_s_out (div_s_w[k+1]),
            .q_s_out   (q_s_w[k+1]),
            .rem_h_out (rem_h_w[k+1]),
            .div_h_out (div_h_w[k+1]),
            .q_h_out   (q_h_w[k+1])
        );
    end

    // Output register: saturation clamps to all ones when the min channel is 0 and the max is not.
    always_comb
    begin
        done_next = ctl_w[FRACTION_BITS].valid;
        hue_next  = q_h_w[FRACTION_BITS];
        if (ctl_w[FRACTION_BITS].sat_full)
        begin
            sat_next = '1;
        end
        else
        begin
            sat_next = q_s_w[FRACTION_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg <= hue_next;
        sat_reg <= sat_next;
        val_reg <= value_w[FRACTION_BITS];
    end

    assign done            = done_reg;
    assign hue_turn        = hue_reg;
    assign saturation_frac = sat_reg;
    assign value_level     = val_reg;

endmodule

// ===== src/rhc_prep.sv =====
`timescale 1ns / 1ps

module rhc_prep
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [CHANNEL_BITS-1:0] red_level,
    input  logic [CHANNEL_BITS-1:0] green_level,
    input  logic [CHANNEL_BITS-1:0] blue_level,
    output ctl_t                    ctl,
    output logic [CHANNEL_BITS-1:0] value,
    output logic [CHANNEL_BITS-1:0] rem_s,
    output logic [CHANNEL_BITS-1:0] div_s,
    output logic [CHANNEL_BITS+2:0] rem_h,
    output logic [CHANNEL_BITS+2:0] div_h
);

    localparam int HW = CHANNEL_BITS + 3;

    logic [CHANNEL_BITS-1:0] mx;
    logic [CHANNEL_BITS-1:0] mn;
    logic [CHANNEL_BITS-1:0] d;
    logic [HW-1:0]           d_w;
    logic [HW-1:0]           r_w;
    logic [HW-1:0]           g_w;
    logic [HW-1:0]           b_w;
    logic [HW-1:0]           six_d;
    logic [HW-1:0]           num;

    ctl_t                    ctl_reg,   ctl_next;
    logic [CHANNEL_BITS-1:0] value_reg, value_next;
    logic [CHANNEL_BITS-1:0] rem_s_reg, rem_s_next;
    logic [CHANNEL_BITS-1:0] div_s_reg, div_s_next;
    logic [HW-1:0]           rem_h_reg, rem_h_next;
    logic [HW-1:0]           div_h_reg, div_h_next;

    always_comb
    begin
        mx = red_level;
        if (green_level > mx)
        begin
            mx = green_level;
        end
        if (blue_level > mx)
        begin
            mx = blue_level;
        end
        mn = red_level;
        if (green_level < mn)
        begin
            mn = green_level;
        end
        if (blue_level < mn)
        begin
            mn = blue_level;
        end
        d     = mx - mn;
        d_w   = HW'(d);
        r_w   = HW'(red_level);
        g_w   = HW'(green_level);
        b_w   = HW'(blue_level);
        six_d = (d_w << 2) + (d_w << 1);

        // sector numerator in 1/d sixths, already wrapped into [0, 6d)
        if (red_level == mx)
        begin
            if (green_level >= blue_level)
            begin
                num = g_w - b_w;
            end
            else
            begin
                num = six_d - (b_w - g_w);
            end
        end
        else if (green_level == mx)
        begin
            num = (d_w << 1) + b_w - r_w;
        end
        else
        begin
            num = (d_w << 2) + r_w - g_w;
        end
    end

    // zero divisors replaced by one with a zero remainder: quotient comes out 0
    always_comb
    begin
        ctl_next.valid    = accept;
        ctl_next.sat_full = (mx != '0) && (mn == '0);
        value_next        = mx;
        if (mx == '0)
        begin
            div_s_next = CHANNEL_BITS'(1);
            rem_s_next = '0;
        end
        else if (mn == '0)
        begin
            div_s_next = mx;
            rem_s_next = '0;
        end
        else
        begin
            div_s_next = mx;
            rem_s_next = d;
        end
        if (d == '0)
        begin
            div_h_next = HW'(1);
            rem_h_next = '0;
        end
        else
        begin
            div_h_next = six_d;
            rem_h_next = num;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        rem_s_reg <= rem_s_next;
        div_s_reg <= div_s_next;
        rem_h_reg <= rem_h_next;
        div_h_reg <= div_h_next;
    end

    assign ctl   = ctl_reg;
    assign value = value_reg;
    assign rem_s = rem_s_reg;
    assign div_s = div_s_reg;
    assign rem_h = rem_h_reg;
    assign div_h = div_h_reg;

endmodule

// ===== src/rhc_div_cell.sv =====
`timescale 1ns / 1ps

module rhc_div_cell
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctl_t                     ctl_in,
    input  logic [CHANNEL_BITS-1:0]  value_in,
    input  logic [CHANNEL_BITS-1:0]  rem_s_in,
    input  logic [CHANNEL_BITS-1:0]  div_s_in,
    input  logic [FRACTION_BITS-1:0] q_s_in,
    input  logic [CHANNEL_BITS+2:0]  rem_h_in,
    input  logic [CHANNEL_BITS+2:0]  div_h_in,
    input  logic [FRACTION_BITS-1:0] q_h_in,
    output ctl_t                     ctl_out,
    output logic [CHANNEL_BITS-1:0]  value_out,
    output logic [CHANNEL_BITS-1:0]  rem_s_out,
    output logic [CHANNEL_BITS-1:0]  div_s_out,
    output logic [FRACTION_BITS-1:0] q_s_out,
    output logic [CHANNEL_BITS+2:0]  rem_h_out,
    output logic [CHANNEL_BITS+2:0]  div_h_out,
    output logic [FRACTION_BITS-1:0] q_h_out
);

    localparam int HW = CHANNEL_BITS + 3;

    // one restoring step for each of the two quotients
    logic [CHANNEL_BITS:0]   sh_s;
    logic [CHANNEL_BITS:0]   diff_s;
    logic                    ge_s;
    logic [HW:0]             sh_h;
    logic [HW:0]             diff_h;
    logic                    ge_h;

    ctl_t                     ctl_reg,   ctl_next;
    logic [CHANNEL_BITS-1:0]  value_reg;
    logic [CHANNEL_BITS-1:0]  rem_s_reg, rem_s_next;
    logic [CHANNEL_BITS-1:0]  div_s_reg;
    logic [FRACTION_BITS-1:0] q_s_reg,   q_s_next;
    logic [HW-1:0]            rem_h_reg, rem_h_next;
    logic [HW-1:0]            div_h_reg;
    logic [FRACTION_BITS-1:0] q_h_reg,   q_h_next;

    always_comb
    begin
        sh_s       = {rem_s_in, 1'b0};
        ge_s       = sh_s >= {1'b0, div_s_in};
        diff_s     = sh_s - {1'b0, div_s_in};
        rem_s_next = ge_s ? diff_s[CHANNEL_BITS-1:0] : sh_s[CHANNEL_BITS-1:0];
        q_s_next   = {q_s_in[FRACTION_BITS-2:0], ge_s};

        sh_h       = {rem_h_in, 1'b0};
        ge_h       = sh_h >= {1'b0, div_h_in};
        diff_h     = sh_h - {1'b0, div_h_in};
        rem_h_next = ge_h ? diff_h[HW-1:0] : sh_h[HW-1:0];
        q_h_next   = {q_h_in[FRACTION_BITS-2:0], ge_h};

        ctl_next   = ctl_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_in;
        rem_s_reg <= rem_s_next;
        div_s_reg <= div_s_in;
        q_s_reg   <= q_s_next;
        rem_h_reg <= rem_h_next;
        div_h_reg <= div_h_in;
        q_h_reg   <= q_h_next;
    end

    assign ctl_out   = ctl_reg;
    assign value_out = value_reg;
    assign rem_s_out = rem_s_reg;
    assign div_s_out = div_s_reg;
    assign q_s_out   = q_s_reg;
    assign rem_h_out = rem_h_reg;
    assign div_h_out = div_h_reg;
    assign q_h_out   = q_h_reg;

endmodule

// ===== src/rhc_checker.sv =====
`timescale 1ns / 1ps

module rhc_checker
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [CHANNEL_BITS-1:0]  red_level,
    input logic [CHANNEL_BITS-1:0]  green_level,
    input logic [CHANNEL_BITS-1:0]  blue_level,
    input logic                     done,
    input logic [FRACTION_BITS-1:0] hue_turn,
    input logic [FRACTION_BITS-1:0] saturation_frac,
    input logic [CHANNEL_BITS-1:0]  value_level
);

    localparam int LAT = FRACTION_BITS + 2;

    // every accepted item comes out a fixed time later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("item accepted but no result after the pipeline latency");

    // no result without an item accepted the same time earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted item");

    // value is the largest channel of the pixel that went in
    a_value_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> value_level >= $past(red_level, LAT)
              && value_level >= $past(green_level, LAT)
              && value_level >= $past(blue_level, LAT)
              && (value_level == $past(red_level, LAT)
                  || value_level == $past(green_level, LAT)
                  || value_level == $past(blue_level, LAT)))
        else $error("value is not the largest channel");

    // black pixel gives zero hue and saturation
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        done && value_level == '0 |-> saturation_frac == '0 && hue_turn == '0)
        else $error("black pixel with non-zero hue or saturation");

endmodule

bind rgb_to_hsv_converter rhc_checker #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_rhc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .red_level       (red_level),
    .green_level     (green_level),
    .blue_level      (blue_level),
    .done            (done),
    .hue_turn        (hue_turn),
    .saturation_frac (saturation_frac),
    .value_level     (value_level)
);

// ===== verif/rgb_to_hsv_checker.sv =====
`timescale 1ns / 1ps

module rgb_to_hsv_checker
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [CHANNEL_BITS-1:0]  red_level,
    input  logic [CHANNEL_BITS-1:0]  green_level,
    input  logic [CHANNEL_BITS-1:0]  blue_level,
    input  logic                     done,
    input  logic [FRACTION_BITS-1:0] hue_turn,
    input  logic [FRACTION_BITS-1:0] saturation_frac,
    input  logic [CHANNEL_BITS-1:0]  value_level,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);

    typedef struct packed {
        logic [CHANNEL_BITS-1:0]  red;
        logic [CHANNEL_BITS-1:0]  green;
        logic [CHANNEL_BITS-1:0]  blue;
        logic [FRACTION_BITS-1:0] hue;
        logic [FRACTION_BITS-1:0] sat;
        logic [CHANNEL_BITS-1:0]  val;
    } hsv_entry_t;

    hsv_entry_t hsv_queue[$];
    int         mismatches = 0;
    int         in_flight  = 0;
    int         results    = 0;

    assign fail_count = mismatches;
    assign pending    = in_flight;
    assign checked    = results;

    // Exact integer HSV: six-sector hue in fractions of a turn, floored
    function automatic hsv_entry_t convert_pixel(input logic [CHANNEL_BITS-1:0] r,
                                                 input logic [CHANNEL_BITS-1:0] g,
                                                 input logic [CHANNEL_BITS-1:0] b);
        longint unsigned rr, gg, bb, mx, mn, d, six_d, num, frac_mask;
        hsv_entry_t      res;
        rr = r;
        gg = g;
        bb = b;
        frac_mask = (64'd1 << FRACTION_BITS) - 1;
        mx = rr;
        mn = rr;
        if (gg > mx) mx = gg;
        if (bb > mx) mx = bb;
        if (gg < mn) mn = gg;
        if (bb < mn) mn = bb;
        d = mx - mn;
        res.red   = r;
        res.green = g;
        res.blue  = b;
        res.val   = mx[CHANNEL_BITS-1:0];
        res.sat   = '0;
        res.hue   = '0;
        if (mx != 0)
        begin
            num = (d << FRACTION_BITS) / mx;
            if (num > frac_mask) num = frac_mask;
            res.sat = num[FRACTION_BITS-1:0];
        end
        if (d != 0)
        begin
            six_d = 6 * d;
            if (rr == mx)
                num = (gg >= bb) ? gg - bb : six_d - (bb - gg);
            else if (gg == mx)
                num = 2 * d + bb - rr;
            else
                num = 4 * d + rr - gg;
            num = ((num << FRACTION_BITS) / six_d) & frac_mask;
            res.hue = num[FRACTION_BITS-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input hsv_entry_t want,
                                   input longint unsigned got, input longint unsigned exp);
        $display("%0t: %s wrong for rgb %0d/%0d/%0d: got %0d, expected %0d",
                 $time, what, want.red, want.green, want.blue, got, exp);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        hsv_entry_t want;
        if (!rst_n)
        begin
            hsv_queue.delete();
            in_flight = 0;
        end
        else
        begin
            if (done)
            begin
                if (hsv_queue.size() == 0)
                begin
                    want = '0;
                    report_mismatch("unexpected result", want, 1, 0);
                end
                else
                begin
                    want = hsv_queue.pop_front();
                    if (hue_turn !== want.hue)
                        report_mismatch("hue", want, hue_turn, want.hue);
                    if (saturation_frac !== want.sat)
                        report_mismatch("saturation", want, saturation_frac, want.sat);
                    if (value_level !== want.val)
                        report_mismatch("value", want, value_level, want.val);
                    results++;
                end
            end
            if (start && !busy)
                hsv_queue.push_back(convert_pixel(red_level, green_level, blue_level));
            in_flight = hsv_queue.size();
        end
    end

endmodule

// ===== verif/tb_rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the RGB to HSV converter. Checking is left to
// rgb_to_hsv_checker, which sits beside the block on the same wires.
module tb_rgb_to_hsv_converter;
    import rhc_pkg::*;

    localparam int CB = CHANNEL_BITS_DEF;
    localparam int FB = FRACTION_BITS_DEF;

    // No item accepted and no result seen for this long means the block is stuck
    localparam int STALL_LIMIT  = 500;
    localparam int RANDOM_ITEMS = 1330;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [CB-1:0] red_level = '0;
    logic [CB-1:0] green_level = '0;
    logic [CB-1:0] blue_level = '0;
    logic          done;
    logic [FB-1:0] hue_turn;
    logic [FB-1:0] saturation_frac;
    logic [CB-1:0] value_level;

    int fail_count;
    int pending;
    int checked;
    int items_sent  = 0;
    int quiet_count = 0;
    int drains      = 0;
    bit bursting    = 1'b0;

    // Corner pixels as 24-bit r/g/b: black, white, greys, primaries,
    // secondaries (ties for largest), red-sector hues that wrap below zero,
    // one-step colours, near-greys and alternating bit patterns.
    logic [23:0] corner_pixels [22] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
        24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'hFF00FF, 24'h00FFFF,
        24'hFF0001, 24'hC80A32, 24'h0AC832, 24'h320AC8,
        24'h010000, 24'h000001, 24'hFFFEFE, 24'hFEFFFF,
        24'hAA550F, 24'h55AAF0, 24'h010203, 24'h7F8081
    };

    rgb_to_hsv_converter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .red_level       (red_level),
        .green_level     (green_level),
        .blue_level      (blue_level),
        .done            (done),
        .hue_turn        (hue_turn),
        .saturation_frac (saturation_frac),
        .value_level     (value_level)
    );

    rgb_to_hsv_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .red_level       (red_level),
        .green_level     (green_level),
        .blue_level      (blue_level),
        .done            (done),
        .hue_turn        (hue_turn),
        .saturation_frac (saturation_frac),
        .value_level     (value_level),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked         (checked)
    );

    always #10 clk = ~clk;

    // Watchdog: any accepted item or result strobe counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= STALL_LIMIT)
        begin
            $display("timeout: no progress for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("FAIL rgb_to_hsv_converter");
            $finish;
        end
    end

    // One item: optional idle gap (start low), then hold start until accepted.
    // Back-to-back items keep start high, so it is never dropped and raised in one step.
    task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                              input logic [CB-1:0] b);
        int gap;
        gap = bursting ? 0 : int'($urandom_range(0, 9));
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start       <= 1'b1;
        red_level   <= r;
        green_level <= g;
        blue_level  <= b;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    // Sender holds off until every outstanding result has come back
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        drains++;
    endtask

    // Random pixel, mostly uniform, with a share of greys, near-greys,
    // ties for the largest channel, and channels pinned at 0 or full scale
    task automatic pick_pixel(output logic [CB-1:0] r, output logic [CB-1:0] g,
                              output logic [CB-1:0] b);
        int          kind;
        logic [CB-1:0] hi, lo, base;
        kind = int'($urandom_range(0, 9));
        r = CB'($urandom_range(0, 255));
        g = CB'($urandom_range(0, 255));
        b = CB'($urandom_range(0, 255));
        hi = CB'($urandom_range(1, 255));
        lo = CB'($urandom_range(0, hi));
        base = CB'($urandom_range(3, 252));
        case (kind)
            5:
            begin
                r = CB'(base + $urandom_range(0, 6) - 3);
                g = CB'(base + $urandom_range(0, 6) - 3);
                b = CB'(base + $urandom_range(0, 6) - 3);
            end
            6:
            begin
                // two channels share the maximum
                case ($urandom_range(0, 2))
                    0: begin r = hi; g = hi; b = lo; end
                    1: begin r = hi; g = lo; b = hi; end
                    default: begin r = lo; g = hi; b = hi; end
                endcase
            end
            7:
            begin
                case ($urandom_range(0, 2))
                    0: r = '0;
                    1: g = '0;
                    default: b = '0;
                endcase
            end
            8:
            begin
                case ($urandom_range(0, 2))
                    0: r = '1;
                    1: g = '1;
                    default: b = '1;
                endcase
            end
            9:
            begin
                g = r;
                b = r;
            end
            default: ;
        endcase
    endtask

    initial
    begin : stimulus
        logic [CB-1:0] r, g, b;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed corners, back to back
        bursting = 1'b1;
        foreach (corner_pixels[i])
            send_pixel(corner_pixels[i][23:16], corner_pixels[i][15:8], corner_pixels[i][7:0]);
        drain_results();

        // Random phase: every 64 items pick at random between bursts and idle gaps,
        // and empty the pipeline now and then
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                bursting = ($urandom_range(0, 2) == 0);
            if (n % 300 == 150)
                drain_results();
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (FB + 4) @(posedge clk);

        $display("Covered %0d pixels: %0d corner cases (black, white, greys, primaries, ties,",
                 items_sent, $size(corner_pixels));
        $display("wrapping red hues) then random ones; %0d results checked, %0d drains",
                 checked, drains);
        if (fail_count == 0 && pending == 0)
            $display("PASS rgb_to_hsv_converter");
        else
            $display("FAIL rgb_to_hsv_converter");
        $finish;
    end

endmodule

// ===== files.f =====
src/rhc_pkg.sv
src/rhc_prep.sv
src/rhc_div_cell.sv
src/rgb_to_hsv_converter.sv
src/rhc_checker.sv
verif/rgb_to_hsv_checker.sv
verif/tb_rgb_to_hsv_converter.sv
